@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file crtrp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/crtrp_pkg.sv @@
// Package: widths, op codes, op classes and the queue entry of the CIGAR position mapper.
package crtrp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CURSOR_W = 32;
    localparam int POS_W    = 31;
    localparam int LEN_W    = 16;
    localparam int OPLEN_W  = 28;
    localparam int CODE_W   = 4;

    localparam logic [CODE_W-1:0] OP_M  = 4'd0;
    localparam logic [CODE_W-1:0] OP_I  = 4'd1;
    localparam logic [CODE_W-1:0] OP_D  = 4'd2;
    localparam logic [CODE_W-1:0] OP_N  = 4'd3;
    localparam logic [CODE_W-1:0] OP_S  = 4'd4;
    localparam logic [CODE_W-1:0] OP_H  = 4'd5;
    localparam logic [CODE_W-1:0] OP_P  = 4'd6;
    localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [CODE_W-1:0] OP_X  = 4'd8;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ALIGN,
        KIND_SKIP,
        KIND_READ
    } op_kind_t;

    typedef struct packed {
        logic                first;
        logic                last;
        logic [POS_W-1:0]    ref_start;
        logic [POS_W-1:0]    target_pos;
        logic [LEN_W-1:0]    read_length;
        op_kind_t            kind;
        logic [OPLEN_W-1:0]  op_length;
    } op_item_t;

endpackage

@@ sv/cigar_ref_to_read_position.sv @@
// Top level of the CIGAR reference-to-read position mapper.
// Maps one reference position into a read by walking the read's CIGAR ops, one op per
// transaction. The first op of a read carries the alignment start, the target position
// and the read length; the last op produces one result (covered, in_deletion,
// read_index). M, = and X are aligned runs, D and N skip reference, I and S consume read
// bases only, H, P and unused codes do nothing. Throughput is one op per clock while no
// stalled result holds back a last op: the back end updates its cursors combinationally
// from registered state (one subtract-and-compare and two saturating adds). A queue of
// QUEUE_DEPTH entries (at least 2) sits between the input and the back end, and the
// result waits in an output register, so a stalled result only blocks the input once the
// queue is full. out_valid rises when the back end pops an accepted last op.
module cigar_ref_to_read_position #(
    parameter int QUEUE_DEPTH = crtrp_pkg::QUEUE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   first_op,
    input  logic                                   last_op,
    input  logic [crtrp_pkg::POS_W-1:0]            ref_start,
    input  logic [crtrp_pkg::POS_W-1:0]            target_pos,
    input  logic [crtrp_pkg::LEN_W-1:0]            read_length,
    input  logic [crtrp_pkg::CODE_W-1:0]           op_code,
    input  logic [crtrp_pkg::OPLEN_W-1:0]          op_length,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   covered,
    output logic                                   in_deletion,
    output logic [crtrp_pkg::LEN_W-1:0]            read_index
);
    import crtrp_pkg::*;

    logic      head_valid;
    logic      head_pop;
    op_item_t  head;

    crtrp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_op    (first_op),
        .last_op     (last_op),
        .ref_start   (ref_start),
        .target_pos  (target_pos),
        .read_length (read_length),
        .op_code     (op_code),
        .op_length   (op_length),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .head        (head)
    );

    crtrp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .head        (head),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .covered     (covered),
        .in_deletion (in_deletion),
        .read_index  (read_index)
    );

endmodule

@@ sv/crtrp_front.sv @@
// Front end: accepts CIGAR op transactions, classifies the op code and queues the item.
module crtrp_front #(
    parameter int DEPTH = crtrp_pkg::QUEUE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   first_op,
    input  logic                                   last_op,
    input  logic [crtrp_pkg::POS_W-1:0]            ref_start,
    input  logic [crtrp_pkg::POS_W-1:0]            target_pos,
    input  logic [crtrp_pkg::LEN_W-1:0]            read_length,
    input  logic [crtrp_pkg::CODE_W-1:0]           op_code,
    input  logic [crtrp_pkg::OPLEN_W-1:0]          op_length,
    output logic                                   head_valid,
    input  logic                                   head_pop,
    output crtrp_pkg::op_item_t                    head
);
    import crtrp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    op_item_t            slot [DEPTH];
    op_item_t            item_in;
    op_kind_t            kind;
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_next;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic                push;

    always_comb
    begin
        unique case (op_code) inside
            OP_M, OP_EQ, OP_X: kind = KIND_ALIGN;
            OP_D, OP_N:        kind = KIND_SKIP;
            OP_I, OP_S:        kind = KIND_READ;
            OP_H, OP_P:        kind = KIND_NONE;
            default:           kind = KIND_NONE;
        endcase
    end

    always_comb
    begin
        item_in.first       = first_op;
        item_in.last        = last_op;
        item_in.ref_start   = ref_start;
        item_in.target_pos  = target_pos;
        item_in.read_length = read_length;
        item_in.kind        = kind;
        item_in.op_length   = op_length;
    end

    assign in_ready   = (count_reg != CntFull);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (head_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, head_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ sv/crtrp_back.sv @@
// Back end: walks the reference and read cursors and holds the result in an output register.
module crtrp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    output logic                          head_pop,
    input  crtrp_pkg::op_item_t           head,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          covered,
    output logic                          in_deletion,
    output logic [crtrp_pkg::LEN_W-1:0]   read_index
);
    import crtrp_pkg::*;

    logic [CURSOR_W-1:0]  ref_reg;
    logic [CURSOR_W-1:0]  ref_next;
    logic [CURSOR_W-1:0]  read_reg;
    logic [CURSOR_W-1:0]  read_next;
    logic [POS_W-1:0]     tgt_reg;
    logic [POS_W-1:0]     tgt_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic                 res_reg;
    logic                 res_next;
    logic                 del_reg;
    logic                 del_next;

    logic [CURSOR_W-1:0]  cur_ref;
    logic [CURSOR_W-1:0]  cur_read;
    logic                 cur_res;
    logic                 tgt_ge;
    logic [POS_W-1:0]     offset;
    logic                 tgt_hit;
    logic [CURSOR_W-1:0]  read_addend;
    logic [CURSOR_W:0]    ref_sum;
    logic [CURSOR_W:0]    read_sum;
    logic [CURSOR_W-1:0]  ref_adv;
    logic [CURSOR_W-1:0]  read_adv;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic                 out_del_reg;
    logic [CURSOR_W-1:0]  out_read_reg;
    logic [LEN_W-1:0]     out_len_reg;

    always_comb
    begin
        cur_ref  = head.first ? {1'b0, head.ref_start} : ref_reg;
        cur_read = head.first ? '0 : read_reg;
        tgt_next = head.first ? head.target_pos : tgt_reg;
        len_next = head.first ? head.read_length : len_reg;
        cur_res  = head.first ? 1'b0 : res_reg;
        del_next = head.first ? 1'b0 : del_reg;

        tgt_ge  = ({1'b0, tgt_next} >= cur_ref);
        offset  = tgt_next - cur_ref[POS_W-1:0];
        tgt_hit = tgt_ge && ({1'b0, offset} < {{(CURSOR_W-OPLEN_W){1'b0}}, head.op_length});

        read_addend = (head.kind == KIND_ALIGN && tgt_hit) ? {1'b0, offset}
                                                            : {{(CURSOR_W-OPLEN_W){1'b0}},
                                                               head.op_length};
        ref_sum  = {1'b0, cur_ref} + {{(CURSOR_W+1-OPLEN_W){1'b0}}, head.op_length};
        read_sum = {1'b0, cur_read} + {1'b0, read_addend};
        ref_adv  = ref_sum[CURSOR_W] ? '1 : ref_sum[CURSOR_W-1:0];
        read_adv = read_sum[CURSOR_W] ? '1 : read_sum[CURSOR_W-1:0];

        ref_next  = cur_ref;
        read_next = cur_read;
        res_next  = cur_res;
        if (!cur_res)
        begin
            case (head.kind)
                KIND_ALIGN:
                begin
                    read_next = read_adv;
                    if (tgt_hit)
                    begin
                        res_next = 1'b1;
                    end
                    else
                    begin
                        ref_next = ref_adv;
                    end
                end
                KIND_SKIP:
                begin
                    if (tgt_hit)
                    begin
                        res_next = 1'b1;
                        del_next = 1'b1;
                    end
                    else
                    begin
                        ref_next = ref_adv;
                    end
                end
                KIND_READ:
                begin
                    read_next = read_adv;
                end
                default:
                begin
                    read_next = cur_read;
                end
            endcase
        end
    end

    assign head_pop = head_valid && (!head.last || !out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= '0;
            read_reg <= '0;
            tgt_reg  <= '0;
            len_reg  <= '0;
            res_reg  <= 1'b0;
            del_reg  <= 1'b0;
        end
        else if (head_pop)
        begin
            ref_reg  <= ref_next;
            read_reg <= read_next;
            tgt_reg  <= tgt_next;
            len_reg  <= len_next;
            res_reg  <= res_next;
            del_reg  <= del_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (head_pop && head.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop && head.last)
        begin
            out_found_reg <= res_next && !del_next;
            out_del_reg   <= del_next;
            out_read_reg  <= read_next;
            out_len_reg   <= len_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign covered     = out_found_reg && (out_read_reg < {{(CURSOR_W-LEN_W){1'b0}}, out_len_reg});
    assign in_deletion = out_del_reg;
    assign read_index  = covered ? out_read_reg[LEN_W-1:0] : '0;

endmodule

@@ sv/crtrp_checker.sv @@
// Port-level checker for the CIGAR position mapper, with its bind to the top level.
`include "assert_macros.svh"

module crtrp_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   first_op,
    input  logic                                   last_op,
    input  logic [crtrp_pkg::POS_W-1:0]            ref_start,
    input  logic [crtrp_pkg::POS_W-1:0]            target_pos,
    input  logic [crtrp_pkg::LEN_W-1:0]            read_length,
    input  logic [crtrp_pkg::CODE_W-1:0]           op_code,
    input  logic [crtrp_pkg::OPLEN_W-1:0]          op_length,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic                                   covered,
    input  logic                                   in_deletion,
    input  logic [crtrp_pkg::LEN_W-1:0]            read_index
);
    import crtrp_pkg::*;

    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
                 in_valid && $stable(first_op) && $stable(last_op) && $stable(ref_start) && $stable(target_pos) && $stable(read_length) && $stable(op_code) && $stable(op_length))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                 $stable(covered) && $stable(in_deletion) && $stable(read_index))
    `ASSERT_SAME(a_cov_not_del, clk, rst_n, out_valid && covered, !in_deletion)
    `ASSERT_SAME(a_idx_zero, clk, rst_n, out_valid && !covered, read_index == '0)

endmodule

bind cigar_ref_to_read_position crtrp_checker u_crtrp_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the CIGAR reference-to-read position mapper.
`timescale 1ns / 1ps

module tb_top;
    import crtrp_pkg::*;

    localparam int ITEM_GOAL = 600;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 8;
    localparam logic [CODE_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [CODE_W-1:0] OP_UNUSED_HI = 4'd15;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0] RLEN_MAX = '1;
    localparam logic [OPLEN_W-1:0] OPLEN_MAX = '1;

    typedef struct packed {
        logic                first;
        logic                last;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    target;
        logic [LEN_W-1:0]    rlen;
        logic [CODE_W-1:0]   code;
        logic [OPLEN_W-1:0]  len;
    } cigar_op_t;

    typedef struct packed {
        logic                cov;
        logic                del;
        logic [LEN_W-1:0]    idx;
    } map_site_t;

    typedef struct packed {
        cigar_op_t           op;
        logic                fixed;
        map_site_t           site;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  first_op;
    logic                  last_op;
    logic [POS_W-1:0]      ref_start;
    logic [POS_W-1:0]      target_pos;
    logic [LEN_W-1:0]      read_length;
    logic [CODE_W-1:0]     op_code;
    logic [OPLEN_W-1:0]    op_length;
    logic                  out_valid;
    logic                  out_ready;
    logic                  covered;
    logic                  in_deletion;
    logic [LEN_W-1:0]      read_index;

    logic [CURSOR_W-1:0]   walk_ref;
    logic [CURSOR_W-1:0]   walk_read;
    logic [POS_W-1:0]      hold_target;
    logic [LEN_W-1:0]      hold_len;
    logic                  found;
    logic                  in_del;

    map_site_t             mapped_pos_q[$];
    map_site_t             want_site;
    dir_row_t              dir_tab[$];

    bit                    src_idle_on;
    bit                    hold_req;
    int                    err_cnt;
    int                    items_sent;
    int                    results_seen;
    int                    hits_seen;
    int                    dels_seen;
    int                    reads_sent;
    int                    sat_walks;
    int                    noise_items;
    int                    hold_cnt;
    int                    sink_cycle;

    cigar_ref_to_read_position dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_op    (first_op),
        .last_op     (last_op),
        .ref_start   (ref_start),
        .target_pos  (target_pos),
        .read_length (read_length),
        .op_code     (op_code),
        .op_length   (op_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .covered     (covered),
        .in_deletion (in_deletion),
        .read_index  (read_index)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [CURSOR_W-1:0] sat_add(input logic [CURSOR_W-1:0] a,
                                                     input logic [CURSOR_W:0] b);
        logic [CURSOR_W+1:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        return (sum > {2'b00, {CURSOR_W{1'b1}}}) ? {CURSOR_W{1'b1}} : sum[CURSOR_W-1:0];
    endfunction

    task automatic walk_cigar_op(input cigar_op_t op, output bit emits,
                                 output map_site_t site);
        logic [CURSOR_W:0] tgt33;
        logic [CURSOR_W:0] ref33;
        logic              hit;
        logic              cov;
        if (op.first)
        begin
            walk_ref = {1'b0, op.start};
            walk_read = '0;
            hold_target = op.target;
            hold_len = op.rlen;
            found = 1'b0;
            in_del = 1'b0;
        end
        if (!found)
        begin
            tgt33 = {2'b00, hold_target};
            ref33 = {1'b0, walk_ref};
            hit = (tgt33 >= ref33) && ((tgt33 - ref33) < {5'b0, op.len});
            case (op.code)
                OP_M, OP_EQ, OP_X:
                begin
                    if (hit)
                    begin
                        walk_read = sat_add(walk_read, tgt33 - ref33);
                        found = 1'b1;
                    end
                    else
                    begin
                        walk_ref = sat_add(walk_ref, {5'b0, op.len});
                        walk_read = sat_add(walk_read, {5'b0, op.len});
                    end
                end
                OP_D, OP_N:
                begin
                    if (hit)
                    begin
                        found = 1'b1;
                        in_del = 1'b1;
                    end
                    else
                    begin
                        walk_ref = sat_add(walk_ref, {5'b0, op.len});
                    end
                end
                OP_I, OP_S:
                begin
                    walk_read = sat_add(walk_read, {5'b0, op.len});
                end
                default:
                begin
                end
            endcase
        end
        emits = op.last;
        cov = found && !in_del && (walk_read < {16'b0, hold_len});
        site.cov = cov;
        site.del = in_del;
        site.idx = cov ? walk_read[LEN_W-1:0] : '0;
    endtask

    task automatic push_op(input cigar_op_t op, input bit fixed, input map_site_t site);
        bit        emits;
        map_site_t pred;
        while (src_idle_on && $urandom_range(0, 99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        first_op = op.first;
        last_op = op.last;
        ref_start = op.start;
        target_pos = op.target;
        read_length = op.rlen;
        op_code = op.code;
        op_length = op.len;
        do @(posedge clk); while (!in_ready);
        walk_cigar_op(op, emits, pred);
        if (emits)
            mapped_pos_q.push_back(fixed ? site : pred);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic cigar_op_t mk_op(input bit f, input bit l, input logic [POS_W-1:0] s,
                                        input logic [POS_W-1:0] t, input logic [LEN_W-1:0] rl,
                                        input logic [CODE_W-1:0] c,
                                        input logic [OPLEN_W-1:0] n);
        cigar_op_t op;
        op.first = f;
        op.last = l;
        op.start = s;
        op.target = t;
        op.rlen = rl;
        op.code = c;
        op.len = n;
        return op;
    endfunction

    function automatic dir_row_t dr(input cigar_op_t op, input bit fx, input bit cv,
                                    input bit dl, input logic [LEN_W-1:0] ix);
        dir_row_t row;
        row.op = op;
        row.fixed = fx;
        row.site.cov = cv;
        row.site.del = dl;
        row.site.idx = ix;
        return row;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return OP_M;
        if (p < 35) return OP_EQ;
        if (p < 45) return OP_X;
        if (p < 53) return OP_D;
        if (p < 60) return OP_N;
        if (p < 68) return OP_I;
        if (p < 76) return OP_S;
        if (p < 82) return OP_H;
        if (p < 88) return OP_P;
        return CODE_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [OPLEN_W-1:0] pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return OPLEN_W'($urandom_range(1, 20));
        if (p < 80) return '0;
        if (p < 88) return OPLEN_MAX;
        return OPLEN_W'($urandom);
    endfunction

    task automatic send_read();
        int                n;
        int                p;
        logic [POS_W-1:0]  s;
        logic [POS_W-1:0]  t;
        logic [LEN_W-1:0]  rl;
        p = $urandom_range(0, 99);
        if (p < 50) s = POS_W'($urandom_range(0, 1000));
        else if (p < 75) s = POS_W'($urandom);
        else s = POS_W'(POS_MAX - $urandom_range(0, 1000));
        p = $urandom_range(0, 99);
        if (p < 60) t = POS_W'(s + $urandom_range(0, 60));
        else if (p < 75) t = POS_W'(s - $urandom_range(1, 10));
        else t = POS_W'($urandom);
        p = $urandom_range(0, 99);
        if (p < 50) rl = LEN_W'($urandom_range(0, 80));
        else if (p < 75) rl = LEN_W'($urandom);
        else rl = ($urandom_range(0, 1) != 0) ? RLEN_MAX : '0;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            push_op(mk_op(k == 0, k == n - 1, s, t, rl, pick_code(), pick_len()), 1'b0, '0);
        reads_sent++;
    endtask

    task automatic send_sat_walk();
        logic [POS_W-1:0]  s;
        logic [POS_W-1:0]  t;
        logic [LEN_W-1:0]  rl;
        bit                on_ref;
        on_ref = ($urandom_range(0, 1) != 0);
        s = on_ref ? POS_W'(POS_MAX - $urandom_range(0, 100))
                   : POS_W'($urandom_range(0, 1000));
        t = on_ref ? POS_W'($urandom) : POS_W'(s + 2);
        rl = LEN_W'($urandom);
        for (int k = 0; k < 18; k++)
        begin
            if (on_ref)
                push_op(mk_op(k == 0, 1'b0, s, t, rl,
                              ($urandom_range(0, 1) != 0) ? OP_D : OP_N, OPLEN_MAX),
                        1'b0, '0);
            else
                push_op(mk_op(k == 0, 1'b0, s, t, rl,
                              ($urandom_range(0, 1) != 0) ? OP_I : OP_S, OPLEN_MAX),
                        1'b0, '0);
        end
        push_op(mk_op(1'b0, 1'b1, s, t, rl, OP_M, on_ref ? OPLEN_MAX : 28'd10), 1'b0, '0);
        sat_walks++;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
        begin
            push_op(mk_op(($urandom_range(0, 1) != 0), ($urandom_range(0, 1) != 0),
                          POS_W'($urandom), POS_W'($urandom), LEN_W'($urandom),
                          CODE_W'($urandom_range(0, 15)), OPLEN_W'($urandom)), 1'b0, '0);
            noise_items++;
        end
    endtask

    task automatic send_pressure_burst();
        logic [POS_W-1:0] s;
        src_idle_on = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
        begin
            s = POS_W'($urandom_range(0, 1000));
            push_op(mk_op(1'b1, 1'b1, s, POS_W'(s + $urandom_range(0, 12)),
                          LEN_W'($urandom_range(0, 20)), OP_M,
                          OPLEN_W'($urandom_range(0, 10))), 1'b0, '0);
        end
    endtask

    task automatic drain_wait();
        in_valid = 1'b0;
        while (mapped_pos_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        hold_req = 1'b0;
        sink_cycle = 0;
        hold_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            sink_cycle++;
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                hold_cnt++;
            end
            out_ready = (sink_cycle % 1000 < 200) || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (covered) hits_seen++;
            if (in_deletion) dels_seen++;
            if (mapped_pos_q.size() == 0)
            begin
                $display("%0t: unexpected result covered=%0b in_deletion=%0b read_index=%0d",
                         $time, covered, in_deletion, read_index);
                err_cnt++;
            end
            else
            begin
                want_site = mapped_pos_q.pop_front();
                if (covered !== want_site.cov)
                begin
                    $display("%0t: covered mismatch, expected %0b, actual %0b",
                             $time, want_site.cov, covered);
                    err_cnt++;
                end
                if (in_deletion !== want_site.del)
                begin
                    $display("%0t: in_deletion mismatch, expected %0b, actual %0b",
                             $time, want_site.del, in_deletion);
                    err_cnt++;
                end
                if (read_index !== want_site.idx)
                begin
                    $display("%0t: read_index mismatch, expected %0d, actual %0d",
                             $time, want_site.idx, read_index);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        first_op = 1'b0;
        last_op = 1'b0;
        ref_start = '0;
        target_pos = '0;
        read_length = '0;
        op_code = OP_M;
        op_length = '0;
        err_cnt = 0;
        items_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        dels_seen = 0;
        reads_sent = 0;
        sat_walks = 0;
        noise_items = 0;
        src_idle_on = 1'b1;
        walk_ref = '0;
        walk_read = '0;
        hold_target = '0;
        hold_len = '0;
        found = 1'b0;
        in_del = 1'b0;

        dir_tab.push_back(dr(mk_op(0, 1, 0, 0, 0, OP_M, 5), 1, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 1, 100, 103, 10, OP_M, 10), 1, 1, 0, 3));
        dir_tab.push_back(dr(mk_op(1, 1, 100, 100, 10, OP_D, 5), 1, 0, 1, 0));
        dir_tab.push_back(dr(mk_op(1, 1, 100, 104, 10, OP_N, 5), 1, 0, 1, 0));
        dir_tab.push_back(dr(mk_op(1, 1, 50, 10, 30, OP_M, 20), 1, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 1, 7, 7, 30, OP_M, 0), 1, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 1, 0, 5, 5, OP_M, 10), 1, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 1, POS_MAX, POS_MAX, RLEN_MAX, OP_EQ, OPLEN_MAX),
                             1, 1, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 1, POS_MAX, 0, 0, OP_X, OPLEN_MAX), 1, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 0, 1000, 1010, 100, OP_S, 3), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_I, 2), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_H, 4), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_P, 6), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_UNUSED_HI, 9), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_UNUSED_LO, 9), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_M, 5), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_D, 3), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_N, 1), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 1, 0, 0, 0, OP_M, 20), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 1, 0, 0, 0, OP_M, 4), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(1, 0, 200, 202, 50, OP_M, 2), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 0, 0, 0, 0, OP_D, 5), 0, 0, 0, 0));
        dir_tab.push_back(dr(mk_op(0, 1, 0, 0, 0, OP_M, 10), 0, 0, 0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            push_op(dir_tab[i].op, dir_tab[i].fixed, dir_tab[i].site);
        drain_wait();

        while (items_sent < ITEM_GOAL)
        begin
            if (reads_sent == 30)
            begin
                send_pressure_burst();
                reads_sent++;
            end
            if (reads_sent % 40 == 39)
                drain_wait();
            src_idle_on = !(reads_sent >= 80 && reads_sent < 110);
            sel = $urandom_range(0, 99);
            if (sel < 82)
                send_read();
            else if (sel < 88)
                send_sat_walk();
            else
                send_noise();
        end
        in_valid = 1'b0;

        while (mapped_pos_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d ops: %0d reads, %0d saturating walks, %0d noise ops, %0d hold-offs.",
                 items_sent, reads_sent, sat_walks, noise_items, hold_cnt);
        $display("Checked %0d results: %0d covered, %0d in deletion, %0d errors.",
                 results_seen, hits_seen, dels_seen, err_cnt);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
